[sv/hrsp_pkg.sv]
`default_nettype none

package hrsp_pkg;

  // Number of known header names
  localparam int unsigned HdrCount = 9;
  localparam int unsigned HdrIdxW  = 4;

  // Byte role codes
  typedef enum logic [2:0] {
    ROLE_METHOD   = 3'd0,
    ROLE_PATH     = 3'd1,
    ROLE_PROTOCOL = 3'd2,
    ROLE_VALUE    = 3'd3,
    ROLE_BODY     = 3'd4,
    ROLE_DELIM    = 3'd5
  } role_e;

  // Method codes
  typedef enum logic [2:0] {
    M_HEAD    = 3'd0,
    M_GET     = 3'd1,
    M_POST    = 3'd2,
    M_PUT     = 3'd3,
    M_UNKNOWN = 3'd4
  } method_e;

  // Content type codes
  typedef enum logic [2:0] {
    CK_HTML  = 3'd0,
    CK_PLAIN = 3'd1,
    CK_GIF   = 3'd2,
    CK_JPEG  = 3'd3,
    CK_PNG   = 3'd4,
    CK_BMP   = 3'd5
  } content_e;

  // Request status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_METH  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  // One tagged byte leaving the parser
  typedef struct packed {
    logic [7:0]         out_byte;
    role_e              role;
    logic [HdrIdxW-1:0] header_index;
    method_e            method_code;
    content_e           content_kind;
    status_e            status;
    logic               out_last;
  } result_t;

endpackage

`default_nettype wire

[sv/hrsp_parse_core.sv]
`default_nettype none

module hrsp_parse_core
  import hrsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,   // one byte is processed this cycle
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output result_t         result_o
);

  // Parse phases; order matters for range checks
  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_PATH   = 3'd1,
    PH_PROT   = 3'd2,
    PH_NAME   = 3'd3,
    PH_VALUE  = 3'd4,
    PH_SKIP   = 3'd5,
    PH_BODY   = 3'd6
  } phase_e;

  localparam logic [HdrIdxW-1:0] HdrNone = '1;
  localparam logic [HdrCount-1:0] AllCand = '1;

  // Header names, right aligned: char k of a name of length L sits at byte L-1-k
  localparam logic [127:0] HdrText [HdrCount] = '{
    128'("Referer:"), 128'("Connection:"), 128'("User-Agent:"), 128'("Host:"),
    128'("Accept:"), 128'("Accept-Encoding:"), 128'("Accept-Charset:"),
    128'("Content-type:"), 128'("Content-length:")
  };
  localparam logic [4:0] HdrLen [HdrCount] = '{
    5'd8, 5'd11, 5'd11, 5'd5, 5'd7, 5'd16, 5'd15, 5'd13, 5'd15
  };

  // Method names, same alignment, indexed by method code
  localparam logic [31:0] MethText [4] = '{"HEAD", 32'("GET"), "POST", 32'("PUT")};
  localparam logic [4:0]  MethLen  [4] = '{5'd4, 5'd3, 5'd4, 5'd3};

  // Upper-cased extension patterns
  localparam logic [31:0] ExtGif  = ".GIF";
  localparam logic [39:0] ExtJpeg = ".JPEG";
  localparam logic [31:0] ExtJpg  = ".JPG";
  localparam logic [31:0] ExtPng  = ".PNG";
  localparam logic [31:0] ExtBmp  = ".BMP";
  localparam logic [31:0] ExtTxt  = ".TXT";

  phase_e              phase_q, phase_d;
  method_e             meth_q, meth_d;
  logic [4:0]          pos_q, pos_d;
  logic [HdrCount-1:0] cand_q, cand_d;
  logic [HdrIdxW-1:0]  hdr_q, hdr_d;
  logic [1:0]          crlf_q, crlf_d;
  logic [39:0]         win_q, win_d;
  logic [4:0]          ext_q, ext_d;
  logic                bad_q, bad_d;

  logic [7:0]          ub;
  logic                is_cr, is_lf, line_end, blank, hit;
  logic [HdrIdxW-1:0]  hit_idx;
  logic [HdrCount-1:0] cand_new;
  logic [4:0]          sh;
  logic [4:0]          msh;
  logic [7:0]          hchar;
  logic [7:0]          mchar;
  role_e               role;
  logic [HdrIdxW-1:0]  hidx;
  method_e             mcode;
  content_e            kind;
  status_e             status;

  // Next state and result for the byte in flight
  always_comb begin
    ub       = (byte_i >= "a" && byte_i <= "z") ? byte_i - 8'd32 : byte_i;
    is_cr    = (byte_i == 8'd13);
    is_lf    = (byte_i == 8'd10);
    line_end = is_lf && (crlf_q == 2'd1 || crlf_q == 2'd3);
    blank    = is_lf && (crlf_q == 2'd3);

    phase_d  = phase_q;
    meth_d   = meth_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    hdr_d    = hdr_q;
    crlf_d   = crlf_q;
    win_d    = win_q;
    ext_d    = ext_q;
    bad_d    = bad_q;
    role     = ROLE_DELIM;
    hidx     = '0;
    cand_new = cand_q;
    hit      = 1'b0;
    hit_idx  = '0;
    sh       = '0;
    hchar    = '0;
    msh      = '0;
    mchar    = '0;

    if (phase_q == PH_BODY) begin
      role = ROLE_BODY;
    end else begin
      // Method prefix check over the first four bytes of the request line
      if (phase_q <= PH_PROT && pos_q < 5'd4) begin
        if (pos_q == 5'd0) begin
          meth_d = (ub == "G") ? M_GET : (ub == "H") ? M_HEAD :
                   (ub == "P") ? M_POST : M_UNKNOWN;
        end else if (meth_q != M_UNKNOWN) begin
          msh   = MethLen[meth_q[1:0]] - 5'd1 - pos_q;
          mchar = MethText[meth_q[1:0]][{msh[1:0], 3'b000} +: 8];
          if (meth_q == M_POST && pos_q == 5'd1 && ub == "U") begin
            meth_d = M_PUT;
          end else if (pos_q < MethLen[meth_q[1:0]] && ub != mchar) begin
            meth_d = M_UNKNOWN;
          end
        end
      end

      // CR LF tracking
      if (is_cr) begin
        crlf_d = (crlf_q == 2'd2) ? 2'd3 : 2'd1;
      end else if (line_end) begin
        crlf_d = 2'd2;
      end else begin
        crlf_d = 2'd0;
      end

      if (line_end) begin
        if (phase_q <= PH_PATH) bad_d = 1'b1;
        if (blank) begin
          phase_d = PH_BODY;
        end else begin
          phase_d = PH_NAME;
          cand_d  = AllCand;
        end
        hdr_d = HdrNone;
        pos_d = '0;
      end else begin
        unique case (phase_q)
          PH_METHOD: begin
            if (byte_i == " ") phase_d = PH_PATH;
            else if (!is_cr) role = ROLE_METHOD;
          end
          PH_PATH: begin
            if (byte_i == " ") begin
              phase_d = PH_PROT;
            end else begin
              win_d = {win_q[31:0], ub};
              if (win_d[31:0] == ExtGif) ext_d[0] = 1'b1;
              if (win_d == ExtJpeg || win_d[31:0] == ExtJpg) ext_d[1] = 1'b1;
              if (win_d[31:0] == ExtPng) ext_d[2] = 1'b1;
              if (win_d[31:0] == ExtBmp) ext_d[3] = 1'b1;
              if (win_d[31:0] == ExtTxt) ext_d[4] = 1'b1;
              if (!is_cr) role = ROLE_PATH;
            end
          end
          PH_PROT: begin
            if (!is_cr) role = ROLE_PROTOCOL;
          end
          PH_NAME: begin
            // Drop names that no longer match at this position
            for (int i = 0; i < HdrCount; i++) begin
              sh    = HdrLen[i] - 5'd1 - pos_q;
              hchar = HdrText[i][{sh[3:0], 3'b000} +: 8];
              if (cand_q[i] && (pos_q >= HdrLen[i] || byte_i != hchar)) cand_new[i] = 1'b0;
            end
            // First complete name in table order wins
            for (int i = HdrCount - 1; i >= 0; i--) begin
              if (cand_new[i] && ({1'b0, HdrLen[i]} == {1'b0, pos_q} + 6'd1)) begin
                hit     = 1'b1;
                hit_idx = HdrIdxW'(i);
              end
            end
            cand_d = cand_new;
            if (hit) begin
              hdr_d   = hit_idx;
              phase_d = PH_VALUE;
            end else if (cand_new == '0) begin
              phase_d = PH_SKIP;
            end
          end
          PH_VALUE: begin
            if (!is_cr) begin
              role = ROLE_VALUE;
              hidx = hdr_q;
            end
          end
          PH_SKIP, PH_BODY: begin
          end
          default: begin
          end
        endcase
        if (pos_q != 5'd31) pos_d = pos_q + 5'd1;
      end
    end

    // Summary fields from the updated state
    if (meth_d != M_UNKNOWN &&
        (phase_d >= PH_NAME || pos_d >= MethLen[meth_d[1:0]])) begin
      mcode = meth_d;
    end else begin
      mcode = M_UNKNOWN;
    end

    priority if (ext_d[0]) kind = CK_GIF;
    else if (ext_d[1])     kind = CK_JPEG;
    else if (ext_d[2])     kind = CK_PNG;
    else if (ext_d[3])     kind = CK_BMP;
    else if (ext_d[4])     kind = CK_PLAIN;
    else                   kind = CK_HTML;

    priority if (meth_d == M_UNKNOWN || (last_i && mcode == M_UNKNOWN)) begin
      status = ST_BAD_METH;
    end else if (bad_d || (last_i && phase_d != PH_BODY)) begin
      status = ST_MALFORMED;
    end else begin
      status = ST_OK;
    end

    result_o.out_byte     = byte_i;
    result_o.role         = role;
    result_o.header_index = hidx;
    result_o.method_code  = mcode;
    result_o.content_kind = kind;
    result_o.status       = status;
    result_o.out_last     = last_i;
  end

  // Parser state; returns to reset after the last byte of a request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
      meth_q  <= M_UNKNOWN;
      pos_q   <= '0;
      cand_q  <= AllCand;
      hdr_q   <= HdrNone;
      crlf_q  <= '0;
      win_q   <= '0;
      ext_q   <= '0;
      bad_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_METHOD;
        meth_q  <= M_UNKNOWN;
        pos_q   <= '0;
        cand_q  <= AllCand;
        hdr_q   <= HdrNone;
        crlf_q  <= '0;
        win_q   <= '0;
        ext_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        meth_q  <= meth_d;
        pos_q   <= pos_d;
        cand_q  <= cand_d;
        hdr_q   <= hdr_d;
        crlf_q  <= crlf_d;
        win_q   <= win_d;
        ext_q   <= ext_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

`default_nettype wire

[sv/http_request_stream_parser_top.sv]
// HTTP request byte parser: tags each byte and reports method, content type and status.
// Each byte passes through the input register, then the result register.
// One byte per cycle unless m_axis_tready stalls; parse state is updated as a byte advances.
// Reset (rst_ni low, asynchronous): both stages empty, parser at the start of a request.
// After a byte with tlast the parser returns to its reset state for the next request.
`default_nettype none

module http_request_stream_parser_top
  import hrsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] method_code,
                                           // [13:11] content_kind, [15:14] status
  output logic [6:0]       m_axis_tuser,   // [2:0] role, [6:3] header_index
  output logic             m_axis_tlast    // out_last
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  result_t    res_q;
  result_t    res_d;
  logic       advance;

  // A byte moves on when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  hrsp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q.status, res_q.content_kind, res_q.method_code, res_q.out_byte};
  assign m_axis_tuser  = {res_q.header_index, res_q.role};
  assign m_axis_tlast  = res_q.out_last;

endmodule

`default_nettype wire
